FILE: sv/ped_pkg.sv
`default_nettype none

package ped_pkg;

   localparam int PRIO_W  = 4;
   localparam int DATA_W  = 32;
   localparam int ENTRY_W = PRIO_W + DATA_W;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [PRIO_W-1:0] THRESHOLD_RESET = 4'd4;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] data;
   } entry_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   item;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: sv/priority_end_deque.sv
`default_nettype none

// Bounded double-ended queue of DEPTH entries (4-bit priority, 32-bit payload) held
// in a row of cells, front at the first cell. Every request item yields one response
// item, registered in the cycle after it is taken; one item is taken per cycle while the
// response side keeps up, since all cells shift or load together as one and the
// back entry is picked by an OR over the cells. An insert at or above the threshold
// goes to the front, else to the back; a remove takes the front unless the back holds
// a strictly higher priority. Threshold writes on csr_ are taken at any time and act
// on the next item.
module priority_end_deque #(
   parameter int DEPTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // priority_req [3:0], payload [35:4], zero fill
   input  wire logic [39:0]                 req_tdata,
   // kind
   input  wire logic                        req_tuser,

   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // out_priority [3:0], out_payload [35:4], from_back, queue_empty, occupancy, zero fill
   output logic [((38+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [1:0]                       rsp_tuser,

   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [ped_pkg::PRIO_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RSP_W = ((38 + CNT_W + 7) / 8) * 8;

   logic                          req_fire;
   logic [ped_pkg::PRIO_W-1:0]    threshold_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;

   logic                          rsp_valid_ff;
   logic [1:0]                    status_ff;
   logic [1:0]                    status_in;
   ped_pkg::entry_type            out_ff;
   ped_pkg::entry_type            out_in;
   logic                          from_back_ff;
   logic                          from_back_in;

   ped_pkg::cell_ctl_type         ctl;
   ped_pkg::entry_type            new_item;
   logic                          cell_valid [DEPTH];
   ped_pkg::entry_type            cell_entry [DEPTH];
   logic [ped_pkg::ENTRY_W-1:0]   cell_back  [DEPTH];
   logic [ped_pkg::ENTRY_W-1:0]   back_bits;
   ped_pkg::entry_type            back_entry;
   logic                          is_empty;
   logic                          is_full;

   assign new_item.prio = req_tdata[3:0];
   assign new_item.data = req_tdata[35:4];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign is_empty = !cell_valid[0];
   assign is_full  = cell_valid[DEPTH-1];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic               lv;
         ped_pkg::entry_type le;
         logic               rv;
         ped_pkg::entry_type re;
         if (g == 0) begin : g_first
            assign lv = 1'b1;
            assign le = new_item;
         end else begin : g_mid
            assign lv = cell_valid[g-1];
            assign le = cell_entry[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign re = cell_entry[g];
         end else begin : g_inner
            assign rv = cell_valid[g+1];
            assign re = cell_entry[g+1];
         end
         ped_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_valid  (lv),
            .left_entry  (le),
            .right_valid (rv),
            .right_entry (re),
            .valid       (cell_valid[g]),
            .entry       (cell_entry[g]),
            .back_bits   (cell_back[g])
         );
      end
   endgenerate

   always_comb begin
      back_bits = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_bits = back_bits | cell_back[i];
      end
   end

   assign back_entry = back_bits;

   always_comb begin
      ctl.op       = ped_pkg::OP_HOLD;
      ctl.item     = new_item;
      status_in    = ped_pkg::ST_OK;
      out_in       = '0;
      from_back_in = 1'b0;
      count_in     = count_ff;
      if (req_tuser == ped_pkg::KIND_INSERT) begin
         if (is_full) begin
            status_in = ped_pkg::ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
            if (new_item.prio >= threshold_ff) begin
               ctl.op = ped_pkg::OP_PUSH_FRONT;
            end else begin
               ctl.op = ped_pkg::OP_PUSH_BACK;
            end
         end
      end else begin
         if (is_empty) begin
            status_in = ped_pkg::ST_EMPTY;
         end else begin
            count_in = count_ff - CNT_W'(1);
            if (cell_entry[0].prio >= back_entry.prio) begin
               ctl.op = ped_pkg::OP_POP_FRONT;
               out_in = cell_entry[0];
            end else begin
               ctl.op       = ped_pkg::OP_POP_BACK;
               out_in       = back_entry;
               from_back_in = 1'b1;
            end
         end
      end
      if (!req_fire) begin
         ctl.op = ped_pkg::OP_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ped_pkg::THRESHOLD_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff    <= status_in;
         out_ff       <= out_in;
         from_back_ff <= from_back_in;
      end
   end

   logic [CNT_W-1:0] occ_ff;
   logic             empty_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         occ_ff   <= count_in;
         empty_ff <= (count_in == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_W'({occ_ff, empty_ff, from_back_ff, out_ff.data, out_ff.prio});

endmodule

`default_nettype wire

FILE: sv/ped_cell.sv
`default_nettype none

module ped_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ped_pkg::cell_ctl_type  ctl,
   input  wire logic                   left_valid,
   input  wire ped_pkg::entry_type     left_entry,
   input  wire logic                   right_valid,
   input  wire ped_pkg::entry_type     right_entry,
   output logic                        valid,
   output ped_pkg::entry_type          entry,
   output logic [ped_pkg::ENTRY_W-1:0] back_bits
);

   logic               valid_ff;
   logic               valid_in;
   ped_pkg::entry_type entry_ff;
   ped_pkg::entry_type entry_in;
   logic               is_back;

   assign is_back   = valid_ff && !right_valid;
   assign valid     = valid_ff;
   assign entry     = entry_ff;
   assign back_bits = is_back ? entry_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      case (ctl.op)
         ped_pkg::OP_PUSH_FRONT: begin
            valid_in = left_valid;
            entry_in = left_entry;
         end
         ped_pkg::OP_PUSH_BACK: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               entry_in = ctl.item;
            end
         end
         ped_pkg::OP_POP_FRONT: begin
            valid_in = right_valid;
            entry_in = right_entry;
         end
         ped_pkg::OP_POP_BACK: begin
            if (is_back) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: sv/ped_checker.sv
`default_nettype none

module ped_checker #(
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((38+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] occ;
   logic             empty;

   assign occ   = rsp_tdata[38 +: CNT_W];
   assign empty = rsp_tdata[37];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no response");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (empty == (occ == '0)))
      else $error("empty flag disagrees with occupancy");

   a_st_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ped_pkg::ST_EMPTY |-> empty && rsp_tdata[36:0] == '0)
      else $error("empty rejection with bad fields");

   a_st_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ped_pkg::ST_FULL |-> occ == CNT_W'(DEPTH))
      else $error("full rejection below capacity");

endmodule

bind priority_end_deque ped_checker #(.DEPTH(DEPTH)) u_ped_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: bench/priority_end_deque_tb.sv
`timescale 1ns / 100ps

module priority_end_deque_tb;

   localparam int DEPTH       = 16;
   localparam int RSP_W       = ((38 + $clog2(DEPTH + 1) + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 195;

   typedef struct packed {
      logic [1:0]                 status;
      logic [ped_pkg::PRIO_W-1:0] prio;
      logic [ped_pkg::DATA_W-1:0] payload;
      logic                       from_back;
      logic                       empty;
      logic [4:0]                 occupancy;
   } deque_result_type;

   class deque_scoreboard;
      logic [ped_pkg::PRIO_W-1:0] ring_prio [DEPTH];
      logic [ped_pkg::DATA_W-1:0] ring_data [DEPTH];
      int                         front_pos;
      int                         back_pos;
      int                         held;
      logic [ped_pkg::PRIO_W-1:0] threshold;
      deque_result_type           awaited [$];
      int                         errors;
      int                         n_requests;
      int                         n_responses;
      int                         n_full;
      int                         n_empty;
      int                         n_back;
      int                         peak;

      function new();
         front_pos   = 0;
         back_pos    = 0;
         held        = 0;
         threshold   = ped_pkg::THRESHOLD_RESET;
         errors      = 0;
         n_requests  = 0;
         n_responses = 0;
         n_full      = 0;
         n_empty     = 0;
         n_back      = 0;
         peak        = 0;
      endfunction

      function void set_threshold(logic [ped_pkg::PRIO_W-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(logic kind, logic [ped_pkg::PRIO_W-1:0] p,
                                 logic [ped_pkg::DATA_W-1:0] d);
         deque_result_type r;
         int               tail_pos;
         r = '0;
         r.status = ped_pkg::ST_OK;
         n_requests++;
         if (kind == ped_pkg::KIND_INSERT) begin
            if (held >= DEPTH) begin
               r.status = ped_pkg::ST_FULL;
               n_full++;
            end else begin
               if (held == 0) begin
                  front_pos = 0;
                  back_pos  = 0;
               end
               if (p >= threshold) begin
                  front_pos = (front_pos + DEPTH - 1) % DEPTH;
                  ring_prio[front_pos] = p;
                  ring_data[front_pos] = d;
               end else begin
                  ring_prio[back_pos] = p;
                  ring_data[back_pos] = d;
                  back_pos = (back_pos + 1) % DEPTH;
               end
               held++;
            end
         end else begin
            if (held == 0) begin
               r.status = ped_pkg::ST_EMPTY;
               n_empty++;
            end else begin
               tail_pos = (back_pos + DEPTH - 1) % DEPTH;
               if (ring_prio[front_pos] >= ring_prio[tail_pos]) begin
                  r.prio    = ring_prio[front_pos];
                  r.payload = ring_data[front_pos];
                  front_pos = (front_pos + 1) % DEPTH;
               end else begin
                  r.prio      = ring_prio[tail_pos];
                  r.payload   = ring_data[tail_pos];
                  r.from_back = 1'b1;
                  back_pos    = tail_pos;
                  n_back++;
               end
               held--;
            end
         end
         if (held > peak) peak = held;
         r.empty     = (held == 0);
         r.occupancy = 5'(held);
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [ped_pkg::DATA_W-1:0] want,
                                  logic [ped_pkg::DATA_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] td, logic [1:0] tu);
         deque_result_type e;
         n_responses++;
         if (awaited.size() == 0) begin
            $error("response item with nothing outstanding");
            errors++;
            return;
         end
         e = awaited.pop_front();
         compare_field("status", 32'(e.status), 32'(tu));
         compare_field("out_priority", 32'(e.prio), 32'(td[3:0]));
         compare_field("out_payload", e.payload, td[35:4]);
         compare_field("from_back", 32'(e.from_back), 32'(td[36]));
         compare_field("queue_empty", 32'(e.empty), 32'(td[37]));
         compare_field("occupancy", 32'(e.occupancy), 32'(td[42:38]));
      endfunction
   endclass

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [39:0]                req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_W-1:0]           rsp_tdata;
   logic [1:0]                 rsp_tuser;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [ped_pkg::PRIO_W-1:0] csr_data   = '0;

   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;
   int                cycles             = 0;
   int                threshold_writes   = 0;

   deque_scoreboard   sb = new();

   priority_end_deque #(
      .DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[3:0], req_tdata[35:4]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   task automatic send_item(logic kind, logic [ped_pkg::PRIO_W-1:0] p,
                            logic [ped_pkg::DATA_W-1:0] d);
      if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, d, p};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_items();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_threshold(logic [ped_pkg::PRIO_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_threshold(value);
      threshold_writes++;
   endtask

   initial begin
      int                         phase;
      int                         remaining;
      int                         burst_len;
      int                         insert_pct;
      int                         k;
      logic [ped_pkg::PRIO_W-1:0] thr;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty, single entry, tie-breaks and the threshold boundary at reset value
      send_item(ped_pkg::KIND_REMOVE, 4'd9, 32'h1234_5678);
      send_item(ped_pkg::KIND_INSERT, 4'd15, 32'hFFFF_FFFF);
      send_item(ped_pkg::KIND_REMOVE, 4'd0, 32'h0);
      send_item(ped_pkg::KIND_INSERT, 4'd0, 32'h0000_0000);
      send_item(ped_pkg::KIND_INSERT, 4'd4, 32'hA5A5_A5A5);
      send_item(ped_pkg::KIND_INSERT, 4'd3, 32'h5A5A_5A5A);
      send_item(ped_pkg::KIND_REMOVE, 4'd15, 32'hFFFF_FFFF);
      send_item(ped_pkg::KIND_REMOVE, 4'd0, 32'h0);
      send_item(ped_pkg::KIND_REMOVE, 4'd0, 32'h0);
      send_item(ped_pkg::KIND_REMOVE, 4'd0, 32'h0);
      send_item(ped_pkg::KIND_INSERT, 4'd5, 32'h8000_0001);
      send_item(ped_pkg::KIND_INSERT, 4'd5, 32'h7FFF_FFFE);
      send_item(ped_pkg::KIND_REMOVE, 4'd0, 32'h0);
      send_item(ped_pkg::KIND_REMOVE, 4'd0, 32'h0);

      for (phase = 0; phase < PHASES; phase++) begin
         drain_items();
         case (phase)
            0: thr = 4'd0;
            1: thr = 4'd15;
            2: thr = 4'd7;
            4: thr = 4'd1;
            5: thr = 4'd14;
            7: thr = ped_pkg::THRESHOLD_RESET;
            default: thr = ped_pkg::PRIO_W'($urandom_range(0, 15));
         endcase
         write_threshold(thr);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 55;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 55;
            end
            default: begin
               sender_idle_pct    = 11;
               receiver_stall_pct = 11;
            end
         endcase

         // bursts that lean to filling, draining or neither, so full and empty both recur
         remaining = PHASE_ITEMS;
         while (remaining > 0) begin
            burst_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            for (k = 0; k < burst_len && remaining > 0; k++) begin
               send_item(($urandom_range(0, 99) < insert_pct) ?
                            ped_pkg::KIND_INSERT : ped_pkg::KIND_REMOVE,
                         ped_pkg::PRIO_W'($urandom_range(0, 15)), $urandom);
               remaining--;
            end
         end
      end

      drain_items();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (5) @(posedge clock);

      $display("%0d request items, %0d response items checked over %0d threshold settings",
               sb.n_requests, sb.n_responses, threshold_writes);
      $display("rejected inserts when full %0d, removes when empty %0d, back removes %0d, peak %0d",
               sb.n_full, sb.n_empty, sb.n_back, sb.peak);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: priority_end_deque.f
sv/ped_pkg.sv
sv/ped_cell.sv
sv/priority_end_deque.sv
sv/ped_checker.sv
bench/priority_end_deque_tb.sv
